FILE: rtl/core/phag_pkg.sv
// Shared types, constants and helpers for the periodic halo address generator.
// No dependencies; every other file in rtl/core imports this package.
package phag_pkg;

	localparam int TILE      = 8;
	localparam int MAX_TILES = 16;
	localparam int PAD       = TILE + 2;
	localparam int PAD2      = PAD * PAD;
	localparam int PAD3      = PAD * PAD * PAD;

	localparam int TILE_W = 4;                      // tile coordinate field
	localparam int CELL_W = 4;                      // cell coordinate field
	localparam int CNT_W  = 5;                      // tile count register
	localparam int NXNY_W = $clog2(MAX_TILES * MAX_TILES + 1);
	localparam int BLK_W  = $clog2(MAX_TILES * MAX_TILES * MAX_TILES);
	localparam int OFS_W  = $clog2(PAD3);
	localparam int IDX_W  = 22;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	typedef logic [TILE_W-1:0]    tile_t;
	typedef logic [CELL_W-1:0]    cell_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [NXNY_W-1:0]    nxny_t;
	typedef logic [BLK_W-1:0]     blk_t;
	typedef logic [OFS_W-1:0]     ofs_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [QPTR_W-1:0]    qptr_t;
	typedef logic [QCNT_W-1:0]    qcnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

	localparam cfg_idx_t REG_TILES_X = 2'd0;
	localparam cfg_idx_t REG_TILES_Y = 2'd1;
	localparam cfg_idx_t REG_TILES_Z = 2'd2;

	localparam cnt_t CNT_RESET = CNT_W'(MAX_TILES);

	// One classified item, as queued between front and back
	typedef struct packed {
		logic  is_halo;
		tile_t dtx;
		tile_t dty;
		tile_t dtz;
		tile_t stx;
		tile_t sty;
		tile_t stz;
		cnt_t  nx;
		nxny_t nxny;
		ofs_t  dofs;
		ofs_t  sofs;
	} entry_t;

	typedef struct packed {
		cnt_t x;
		cnt_t y;
		cnt_t z;
	} cfg_t;

	function automatic ofs_t cell_ofs(cell_t i, cell_t j, cell_t k);
		return OFS_W'(k) * OFS_W'(PAD2) + OFS_W'(j) * OFS_W'(PAD) + OFS_W'(i);
	endfunction

endpackage

FILE: rtl/core/phag_front.sv
// Front end: clamps counts and coordinates, maps each axis to its neighbour
// tile and position, and builds a queue entry. Depends on phag_pkg.
module phag_front (
	input  phag_pkg::cfg_t   cfg,
	input  phag_pkg::tile_t  tile_x,
	input  phag_pkg::tile_t  tile_y,
	input  phag_pkg::tile_t  tile_z,
	input  phag_pkg::cell_t  cell_i,
	input  phag_pkg::cell_t  cell_j,
	input  phag_pkg::cell_t  cell_k,
	output phag_pkg::entry_t entry
);
	import phag_pkg::*;

	localparam cell_t LIM = CELL_W'(TILE + 1);

	function automatic cnt_t eff_count(cnt_t v);
		if (v == '0) return cnt_t'(1);
		if (v > CNT_W'(MAX_TILES)) return CNT_W'(MAX_TILES);
		return v;
	endfunction

	function automatic tile_t sat_tile(tile_t t, cnt_t n);
		if (CNT_W'(t) >= n) return TILE_W'(n - cnt_t'(1));
		return t;
	endfunction

	function automatic cell_t sat_cell(cell_t c);
		return (c > LIM) ? LIM : c;
	endfunction

	cnt_t  nx, ny, nz;
	tile_t tx, ty, tz;
	cell_t ci, cj, ck;
	tile_t sx, sy, sz;
	cell_t si, sj, sk;
	logic  hx, hy, hz;

	// Halo on low side pulls from previous tile at TILE, high side from next at 1
	function automatic logic [TILE_W+CELL_W:0] map_axis(cell_t c, tile_t t, cnt_t n);
		tile_t nt;
		cell_t nc;
		logic  h;
		if (c == '0) begin
			nt = (t == '0) ? TILE_W'(n - cnt_t'(1)) : t - tile_t'(1);
			nc = CELL_W'(TILE);
			h  = 1'b1;
		end else if (c == LIM) begin
			nt = ((CNT_W'(t) + cnt_t'(1)) >= n) ? '0 : t + tile_t'(1);
			nc = cell_t'(1);
			h  = 1'b1;
		end else begin
			nt = t;
			nc = c;
			h  = 1'b0;
		end
		return {h, nt, nc};
	endfunction

	always_comb begin
		nx = eff_count(cfg.x);
		ny = eff_count(cfg.y);
		nz = eff_count(cfg.z);
		tx = sat_tile(tile_x, nx);
		ty = sat_tile(tile_y, ny);
		tz = sat_tile(tile_z, nz);
		ci = sat_cell(cell_i);
		cj = sat_cell(cell_j);
		ck = sat_cell(cell_k);
		{hx, sx, si} = map_axis(ci, tx, nx);
		{hy, sy, sj} = map_axis(cj, ty, ny);
		{hz, sz, sk} = map_axis(ck, tz, nz);
	end

	always_comb begin
		entry.is_halo = hx | hy | hz;
		entry.dtx     = tx;
		entry.dty     = ty;
		entry.dtz     = tz;
		entry.stx     = sx;
		entry.sty     = sy;
		entry.stz     = sz;
		entry.nx      = nx;
		entry.nxny    = NXNY_W'(nx) * NXNY_W'(ny);
		entry.dofs    = cell_ofs(ci, cj, ck);
		entry.sofs    = cell_ofs(si, sj, sk);
	end

endmodule

FILE: rtl/core/phag_queue.sv
// Short entry queue that decouples the front end from the index pipeline.
// Depends on phag_pkg for the entry type and depth.
module phag_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  phag_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic             not_empty,
	output phag_pkg::entry_t rd_data
);
	import phag_pkg::*;

	entry_t slot_q [QDEPTH];
	qptr_t  wr_ptr_q, rd_ptr_q;
	qcnt_t  count_q;
	logic   do_wr, do_rd;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en & ~full;
	assign do_rd     = rd_en & not_empty;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + qptr_t'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + qptr_t'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + qcnt_t'(1);
				2'b01:   count_q <= count_q - qcnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/phag_back.sv
// Index pipeline: tile number in stage 1, flat indices in stage 2 (output slot).
// Depends on phag_pkg.
module phag_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  phag_pkg::entry_t in_entry,
	output logic             in_take,
	output logic             empty,
	input  logic             pop,
	output logic             is_halo,
	output phag_pkg::idx_t   dest_index,
	output phag_pkg::idx_t   source_index
);
	import phag_pkg::*;

	logic v_s1, v_s2;
	logic halo_s1, halo_s2;
	blk_t dblk_s1, sblk_s1;
	ofs_t dofs_s1, sofs_s1;
	idx_t didx_s2, sidx_s2;
	logic adv_s1, adv_s2;

	// stall chain: a stage moves when the one after it can take its item
	assign adv_s2  = ~v_s2 | pop;
	assign adv_s1  = ~v_s1 | adv_s2;
	assign in_take = in_valid & adv_s1;

	function automatic blk_t blk_num(tile_t t0, tile_t t1, tile_t t2, cnt_t nx, nxny_t nxny);
		return BLK_W'(t0) + BLK_W'(t1) * BLK_W'(nx) + BLK_W'(t2) * BLK_W'(nxny);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			halo_s1 <= in_entry.is_halo;
			dblk_s1 <= blk_num(in_entry.dtx, in_entry.dty, in_entry.dtz,
				in_entry.nx, in_entry.nxny);
			sblk_s1 <= blk_num(in_entry.stx, in_entry.sty, in_entry.stz,
				in_entry.nx, in_entry.nxny);
			dofs_s1 <= in_entry.dofs;
			sofs_s1 <= in_entry.sofs;
		end
		if (adv_s2 && v_s1) begin
			halo_s2 <= halo_s1;
			didx_s2 <= IDX_W'(dblk_s1) * IDX_W'(PAD3) + IDX_W'(dofs_s1);
			sidx_s2 <= IDX_W'(sblk_s1) * IDX_W'(PAD3) + IDX_W'(sofs_s1);
		end
	end

	assign empty        = ~v_s2;
	assign is_halo      = halo_s2;
	assign dest_index   = didx_s2;
	assign source_index = sidx_s2;

endmodule

FILE: rtl/core/periodic_halo_address_generator.sv
// Top level of the periodic halo address generator: tile count registers,
// front end, entry queue and index pipeline. Depends on phag_pkg, phag_front,
// phag_queue and phag_back.
//
//  channel  handshake          transfer when          payload
//  input    push / full        push & !full           tile_x/y/z, cell_i/j/k
//  result   empty / pop        pop & !empty           is_halo, dest_index, source_index
//  config   cfg_valid / ready  cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while pop keeps the output slot moving; a result
// passes the queue write, the tile number stage and the index multiply stage.
// Reset sets all tile counts to 16 and empties queue and pipeline.
// With pop held low the output slot and stage 1 hold, the four-entry queue
// fills and full rises. cfg_ready is always high.
module periodic_halo_address_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  phag_pkg::tile_t      tile_x,
	input  phag_pkg::tile_t      tile_y,
	input  phag_pkg::tile_t      tile_z,
	input  phag_pkg::cell_t      cell_i,
	input  phag_pkg::cell_t      cell_j,
	input  phag_pkg::cell_t      cell_k,
	output logic                 empty,
	input  logic                 pop,
	output logic                 is_halo,
	output phag_pkg::idx_t       dest_index,
	output phag_pkg::idx_t       source_index,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  phag_pkg::cfg_idx_t   cfg_index,
	input  phag_pkg::cfg_dat_t   cfg_data
);
	import phag_pkg::*;

	cfg_t   cfg_q;
	entry_t fe_entry, q_entry;
	logic   q_not_empty, q_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x <= CNT_RESET;
			cfg_q.y <= CNT_RESET;
			cfg_q.z <= CNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TILES_X: cfg_q.x <= CNT_W'(cfg_data);
				REG_TILES_Y: cfg_q.y <= CNT_W'(cfg_data);
				REG_TILES_Z: cfg_q.z <= CNT_W'(cfg_data);
				default:     cfg_q   <= cfg_q;
			endcase
		end
	end

	phag_front u_front (
		.cfg    (cfg_q),
		.tile_x (tile_x),
		.tile_y (tile_y),
		.tile_z (tile_z),
		.cell_i (cell_i),
		.cell_j (cell_j),
		.cell_k (cell_k),
		.entry  (fe_entry)
	);

	phag_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (fe_entry),
		.full      (full),
		.rd_en     (q_take),
		.not_empty (q_not_empty),
		.rd_data   (q_entry)
	);

	phag_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_not_empty),
		.in_entry     (q_entry),
		.in_take      (q_take),
		.empty        (empty),
		.pop          (pop),
		.is_halo      (is_halo),
		.dest_index   (dest_index),
		.source_index (source_index)
	);

endmodule

FILE: tb/tb_periodic_halo_address_generator.sv
// Self-checking testbench for periodic_halo_address_generator: directed corner items,
// then random items under several tile-count settings, with both sides stalling.
// Depends on phag_pkg and the generator RTL.
module tb_periodic_halo_address_generator;
	import phag_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 163;

	typedef int unsigned axis3_t [3];

	typedef struct {
		logic halo;
		idx_t dest;
		idx_t src;
	} addr_pair_t;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	tile_t    tile_x, tile_y, tile_z;
	cell_t    cell_i, cell_j, cell_k;
	logic     empty;
	logic     pop;
	logic     is_halo;
	idx_t     dest_index;
	idx_t     source_index;
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	cfg_dat_t cfg_data;

	int cycles;
	int items_sent;
	int settings_used;

	// Predicts the destination/source pair of each accepted item and holds
	// the pairs still owed by the block, oldest first.
	class halo_pair_board;
		cnt_t       cnt_x, cnt_y, cnt_z;
		addr_pair_t due_pairs [$];
		int         failures;
		int         checked;
		int         halo_seen;

		function new();
			cnt_x = CNT_RESET;
			cnt_y = CNT_RESET;
			cnt_z = CNT_RESET;
		endfunction

		function int unsigned tiles_in_use(cnt_t v);
			if (v == 0)
				return 1;
			if (v > MAX_TILES)
				return MAX_TILES;
			return 32'(v);
		endfunction

		function void set_reg(cfg_idx_t idx, cfg_dat_t v);
			case (idx)
				REG_TILES_X: cnt_x = v;
				REG_TILES_Y: cnt_y = v;
				REG_TILES_Z: cnt_z = v;
				default: ;
			endcase
		endfunction

		function idx_t flat_index(axis3_t t, axis3_t c, int unsigned nx, int unsigned ny);
			int unsigned blk;
			blk = t[0] + t[1] * nx + t[2] * nx * ny;
			return idx_t'(blk * PAD3 + c[2] * PAD2 + c[1] * PAD + c[0]);
		endfunction

		function void note_item(tile_t tx, tile_t ty, tile_t tz,
				cell_t ci, cell_t cj, cell_t ck);
			axis3_t     n, dt, dc, st, sc;
			addr_pair_t p;
			n  = '{tiles_in_use(cnt_x), tiles_in_use(cnt_y), tiles_in_use(cnt_z)};
			dt = '{32'(tx), 32'(ty), 32'(tz)};
			dc = '{32'(ci), 32'(cj), 32'(ck)};
			p.halo = 1'b0;
			for (int a = 0; a < 3; a++) begin
				if (dt[a] >= n[a])
					dt[a] = n[a] - 1;
				if (dc[a] > TILE + 1)
					dc[a] = TILE + 1;
				if (dc[a] == 0) begin
					// low face: last interior layer of the previous tile
					st[a] = (dt[a] == 0) ? n[a] - 1 : dt[a] - 1;
					sc[a] = TILE;
					p.halo = 1'b1;
				end else if (dc[a] == TILE + 1) begin
					st[a] = (dt[a] + 1 >= n[a]) ? 0 : dt[a] + 1;
					sc[a] = 1;
					p.halo = 1'b1;
				end else begin
					st[a] = dt[a];
					sc[a] = dc[a];
				end
			end
			p.dest = flat_index(dt, dc, n[0], n[1]);
			p.src  = flat_index(st, sc, n[0], n[1]);
			due_pairs.push_back(p);
		endfunction

		function void check_pair(logic h, idx_t d, idx_t s);
			addr_pair_t p;
			if (due_pairs.size() == 0) begin
				$error("unexpected result: is_halo %0d dest %0d source %0d", h, d, s);
				failures++;
				return;
			end
			p = due_pairs.pop_front();
			checked++;
			if (p.halo)
				halo_seen++;
			if (h !== p.halo) begin
				$error("is_halo mismatch: expected %0d, got %0d", p.halo, h);
				failures++;
			end
			if (d !== p.dest) begin
				$error("dest_index mismatch: expected %0d, got %0d", p.dest, d);
				failures++;
			end
			if (s !== p.src) begin
				$error("source_index mismatch: expected %0d, got %0d", p.src, s);
				failures++;
			end
		endfunction

		function int pending();
			return due_pairs.size();
		endfunction
	endclass

	halo_pair_board board;

	periodic_halo_address_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.tile_x       (tile_x),
		.tile_y       (tile_y),
		.tile_z       (tile_z),
		.cell_i       (cell_i),
		.cell_j       (cell_j),
		.cell_k       (cell_k),
		.empty        (empty),
		.pop          (pop),
		.is_halo      (is_halo),
		.dest_index   (dest_index),
		.source_index (source_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, board.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(tile_t tx, tile_t ty, tile_t tz, cell_t ci, cell_t cj, cell_t ck);
		push   <= 1'b1;
		tile_x <= tx;
		tile_y <= ty;
		tile_z <= tz;
		cell_i <= ci;
		cell_j <= cj;
		cell_k <= ck;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_item(tx, ty, tz, ci, cj, ck);
		items_sent++;
	endtask

	task automatic sender_pause(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off the sender until every owed result has been popped.
	task automatic drain_results();
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tile_counts(cfg_dat_t x, cfg_dat_t y, cfg_dat_t z);
		cfg_idx_t idx [3];
		cfg_dat_t val [3];
		idx = '{REG_TILES_X, REG_TILES_Y, REG_TILES_Z};
		val = '{x, y, z};
		drain_results();
		for (int a = 0; a < 3; a++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[a];
			cfg_data  <= val[a];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			board.set_reg(idx[a], val[a]);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic cfg_dat_t pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return cfg_dat_t'($urandom_range(1, MAX_TILES));
		if (r < 72)
			return cfg_dat_t'(1);
		if (r < 84)
			return cfg_dat_t'(MAX_TILES);
		return cfg_dat_t'($urandom_range(0, 31));
	endfunction

	function automatic tile_t pick_tile(cnt_t c);
		if ($urandom_range(0, 99) < 15)
			return tile_t'($urandom_range(0, 15));
		return tile_t'($urandom_range(0, board.tiles_in_use(c) - 1));
	endfunction

	function automatic cell_t pick_cell();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 50)
			return cell_t'(TILE + 1);
		if (r < 92)
			return cell_t'($urandom_range(1, TILE));
		return cell_t'($urandom_range(TILE + 2, 15));
	endfunction

	task automatic send_random_item();
		send_item(pick_tile(board.cnt_x), pick_tile(board.cnt_y), pick_tile(board.cnt_z),
			pick_cell(), pick_cell(), pick_cell());
	endtask

	// Result side: pops with short and long stalls, and calm stretches without any.
	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm  = 0;
		pop <= 1'b0;
		repeat (8) @(posedge clk);
		forever begin
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (calm > 0) begin
					calm--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3)
						calm = $urandom_range(50, 200);
					else if (r < 6)
						stall = $urandom_range(15, 60);
					else if (r < 30)
						stall = $urandom_range(1, 3);
				end
			end
			@(posedge clk);
			if (pop && !empty)
				board.check_pair(is_halo, dest_index, source_index);
		end
	end

	initial begin
		bit steady;
		board = new();
		items_sent    = 0;
		settings_used = 1;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		tile_x    <= '0;
		tile_y    <= '0;
		tile_z    <= '0;
		cell_i    <= '0;
		cell_j    <= '0;
		cell_k    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TILES_X;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset counts: wrap at both ends, interior, saturated cells, single-axis halo
		send_item(0, 0, 0, 0, 0, 0);
		send_item(15, 15, 15, 9, 9, 9);
		send_item(5, 6, 7, 1, 1, 1);
		send_item(0, 0, 0, 8, 8, 8);
		send_item(3, 4, 5, 4, 5, 6);
		send_item(2, 3, 4, 15, 10, 12);
		send_item(7, 7, 7, 10, 1, 1);
		send_item(4, 4, 4, 0, 5, 5);
		send_item(4, 4, 4, 5, 9, 5);
		send_item(4, 4, 4, 5, 5, 0);
		send_item(15, 0, 15, 0, 9, 0);

		// single tile on x, zero count on y, oversized count on z
		set_tile_counts(1, 0, 31);
		send_item(0, 0, 0, 0, 9, 0);
		send_item(15, 15, 15, 9, 0, 9);
		send_item(7, 3, 15, 4, 4, 4);
		send_item(0, 0, 15, 9, 9, 9);

		set_tile_counts(3, 17, 2);
		send_item(3, 15, 1, 0, 0, 9);
		send_item(14, 0, 0, 9, 9, 0);
		send_item(1, 1, 1, 1, 8, 1);
		send_item(2, 15, 1, 9, 9, 9);
		send_item(0, 0, 0, 0, 0, 0);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_tile_counts(1, 1, 1);
				1: set_tile_counts(16, 16, 16);
				2: set_tile_counts(2, 16, 1);
				default: set_tile_counts(pick_count(), pick_count(), pick_count());
			endcase
			steady = (ph % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random_item();
				if (!steady)
					sender_pause(gap_len());
				if (ph == 4 && n == PHASE_ITEMS / 2)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d results never arrived", board.pending());
			board.failures++;
		end

		$display("%0d items sent under %0d tile-count settings", items_sent, settings_used);
		$display("%0d address pairs checked, %0d of them halo cells",
			board.checked, board.halo_seen);
		if (board.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/phag_pkg.sv
rtl/core/phag_front.sv
rtl/core/phag_queue.sv
rtl/core/phag_back.sv
rtl/core/periodic_halo_address_generator.sv
tb/tb_periodic_halo_address_generator.sv
